FILE: rtl/gng_pkg.sv
// Shared types, constants and helpers of the gradient noise generator.
package gng_pkg;

    typedef logic signed [31:0] sword_t;
    typedef logic [13:0] ease_t;

    typedef enum logic [1:0] {
        DIMS_1 = 2'd1,
        DIMS_2 = 2'd2,
        DIMS_3 = 2'd3
    } dims_t;

    typedef struct packed {
        logic  valid;
        dims_t dims;
        logic  byte_mode;
    } ctl_t;

    typedef logic [16:0] cell_arr_t [3];
    typedef logic [15:0] frac_arr_t [3];
    typedef ease_t       ease_arr_t [3];
    typedef logic [31:0] word_arr_t [3];
    typedef logic [31:0] hash_arr_t [8];
    typedef sword_t      grad_arr_t [8];

    localparam logic [31:0] AXIS_MUL [3] = '{32'h27D4EB2D, 32'hB5297A4D, 32'h1B56C4E9};
    localparam logic [31:0] MIX_MUL = 32'h92C3412B;
    localparam sword_t      GRAD3_MUL = 32'sd85;

    localparam logic [11:0] SCALE_1D  = 12'd1159;
    localparam logic [11:0] SCALE_2D  = 12'd1537;
    localparam logic [11:0] SCALE_3D  = 12'd1731;
    localparam logic [11:0] SCALE_1DB = 12'd1353;
    localparam logic [11:0] SCALE_2DB = 12'd1620;
    localparam logic [11:0] SCALE_3DB = 12'd2015;
    localparam sword_t OFFSET_1D  = 32'sd32803;
    localparam sword_t OFFSET_2D  = 32'sd32725;
    localparam sword_t OFFSET_3D  = 32'sd33147;
    localparam sword_t OFFSET_1DB = 32'sd32769;
    localparam sword_t OFFSET_2DB = 32'sd32771;
    localparam sword_t OFFSET_3DB = 32'sd33168;

    // gradient slope (-2..1) times distance
    function automatic sword_t grad_term(input logic [1:0] hb, input sword_t d);
        sword_t r;
        case (hb)
            2'd0:    r = -(d <<< 1);
            2'd1:    r = -d;
            2'd2:    r = '0;
            default: r = d;
        endcase
        return r;
    endfunction

    function automatic sword_t lerp(input sword_t a, input sword_t b, input ease_t t);
        sword_t diff;
        sword_t prod;
        diff = b - a;
        prod = sword_t'(diff * $signed({18'd0, t}));
        return a + (prod >>> 14);
    endfunction

endpackage

FILE: rtl/gradient_noise_generator_unit.sv
// Top level of the fixed-point gradient noise generator.
// Usage:
//   Drive coord_x, coord_y, coord_z, num_dims and byte_mode and raise start
//   for one cycle; the item transfers at that edge. busy is always low, so
//   an item may transfer in every clock cycle.
//   Each item yields one result: raw_noise and noise_value are shown for
//   exactly one cycle with done high, once the item has passed every register
//   stage of the pipeline.
//   Results leave in the order the items arrived.
// Latency and throughput:
//   Ten register stages: one input stage, four in the corner hash, five in
//   interpolation and scaling; the smoothstep runs alongside the hash.
//   One item per cycle.
// Reset:
//   rst_n clears all valid bits; items in flight are dropped and done stays
//   low until new items arrive.
// The receiver has no hold-off; every result must be taken when shown.
module gradient_noise_generator_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        coord_x,
    input  logic [31:0]        coord_y,
    input  logic [31:0]        coord_z,
    input  logic [1:0]         num_dims,
    input  logic               byte_mode,
    output logic               done,
    output logic signed [15:0] raw_noise,
    output logic [15:0]        noise_value
);

    gng_pkg::ctl_t      in_ctl_reg;
    gng_pkg::cell_arr_t lo_reg, hi_reg;
    gng_pkg::frac_arr_t frac_reg, ease_frac;
    gng_pkg::ctl_t      hash_ctl;
    gng_pkg::grad_arr_t grad;
    gng_pkg::ease_arr_t ease, ease_d1_reg, ease_d2_reg;
    logic [31:0]        coord [3];

    assign busy = 1'b0;
    assign coord[0] = coord_x;
    assign coord[1] = coord_y;
    assign coord[2] = coord_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ctl_reg.valid     <= 1'b0;
            in_ctl_reg.dims      <= gng_pkg::DIMS_1;
            in_ctl_reg.byte_mode <= 1'b0;
        end
        else
        begin
            in_ctl_reg.valid <= start && !busy;
            case (num_dims)
                gng_pkg::DIMS_2: in_ctl_reg.dims <= gng_pkg::DIMS_2;
                gng_pkg::DIMS_3: in_ctl_reg.dims <= gng_pkg::DIMS_3;
                default:         in_ctl_reg.dims <= gng_pkg::DIMS_1;
            endcase
            in_ctl_reg.byte_mode <= byte_mode;
        end
    end

    always_ff @(posedge clk)
    begin
        logic [31:0] c;
        for (int i = 0; i < 3; i++)
        begin
            c = byte_mode ? {8'd0, coord[i][15:0], 8'd0} : coord[i];
            lo_reg[i]   <= {1'b0, c[31:16]};
            hi_reg[i]   <= byte_mode ? {9'd0, 8'(c[23:16] + 8'd1)}
                                     : 17'({1'b0, c[31:16]} + 17'd1);
            frac_reg[i] <= c[15:0];
        end
        ease_d1_reg <= ease;
        ease_d2_reg <= ease_d1_reg;
    end

    // unused axes blend with zero weight
    assign ease_frac[0] = frac_reg[0];
    assign ease_frac[1] = (in_ctl_reg.dims != gng_pkg::DIMS_1) ? frac_reg[1] : '0;
    assign ease_frac[2] = (in_ctl_reg.dims == gng_pkg::DIMS_3) ? frac_reg[2] : '0;

    gng_hash u_hash (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctl  (in_ctl_reg),
        .cell_lo (lo_reg),
        .cell_hi (hi_reg),
        .frac    (frac_reg),
        .out_ctl (hash_ctl),
        .grad    (grad)
    );

    gng_ease u_ease (
        .clk  (clk),
        .frac (ease_frac),
        .ease (ease)
    );

    gng_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctl    (hash_ctl),
        .grad      (grad),
        .ease      (ease_d2_reg),
        .out_valid (done),
        .raw_out   (raw_noise),
        .value_out (noise_value)
    );

endmodule

FILE: rtl/gng_ease.sv
// Two-stage cubic smoothstep of the three fractions.
module gng_ease (
    input  logic                clk,
    input  gng_pkg::frac_arr_t  frac,
    output gng_pkg::ease_arr_t  ease
);

    logic [15:0] sq_reg [3];
    logic [17:0] f_reg [3];
    gng_pkg::ease_arr_t ease_reg;

    always_ff @(posedge clk)
    begin
        logic [31:0] sq_full;
        for (int i = 0; i < 3; i++)
        begin
            sq_full = {16'd0, frac[i]} * {16'd0, frac[i]};
            sq_reg[i] <= sq_full[31:16];
            f_reg[i]  <= 18'(18'd196608 - {1'b0, frac[i], 1'b0});
            ease_reg[i] <= gng_pkg::ease_t'(32'({16'd0, sq_reg[i]} * {14'd0, f_reg[i]}) >> 18);
        end
    end

    assign ease = ease_reg;

endmodule

FILE: rtl/gng_hash.sv
// Four-stage corner hash and gradient evaluation for all eight corners.
module gng_hash (
    input  logic                clk,
    input  logic                rst_n,
    input  gng_pkg::ctl_t       in_ctl,
    input  gng_pkg::cell_arr_t  cell_lo,
    input  gng_pkg::cell_arr_t  cell_hi,
    input  gng_pkg::frac_arr_t  frac,
    output gng_pkg::ctl_t       out_ctl,
    output gng_pkg::grad_arr_t  grad
);

    gng_pkg::ctl_t      s1_ctl_reg, s2_ctl_reg, s3_ctl_reg, s4_ctl_reg;
    gng_pkg::word_arr_t p_lo_reg, p_hi_reg;
    gng_pkg::frac_arr_t s1_frac_reg, s2_frac_reg, s3_frac_reg;
    gng_pkg::hash_arr_t h2_next, h2_reg, h3_reg;
    gng_pkg::grad_arr_t g_next, g_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
            s4_ctl_reg <= '0;
        end
        else
        begin
            s1_ctl_reg <= in_ctl;
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s2_ctl_reg;
            s4_ctl_reg <= s3_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            p_lo_reg[i] <= 32'(cell_lo[i] * gng_pkg::AXIS_MUL[i]);
            p_hi_reg[i] <= 32'(cell_hi[i] * gng_pkg::AXIS_MUL[i]);
        end
        s1_frac_reg <= frac;
        s2_frac_reg <= s1_frac_reg;
        s3_frac_reg <= s2_frac_reg;
        h2_reg <= h2_next;
        for (int k = 0; k < 8; k++)
        begin
            h3_reg[k] <= 32'(h2_reg[k] * gng_pkg::MIX_MUL);
        end
        g_reg <= g_next;
    end

    always_comb
    begin
        logic [31:0] h;
        for (int k = 0; k < 8; k++)
        begin
            h = k[2] ? p_hi_reg[0] : p_lo_reg[0];
            if (s1_ctl_reg.dims != gng_pkg::DIMS_1)
            begin
                h = h ^ (k[1] ? p_hi_reg[1] : p_lo_reg[1]);
            end
            if (s1_ctl_reg.dims == gng_pkg::DIMS_3)
            begin
                h = h ^ (k[0] ? p_hi_reg[2] : p_lo_reg[2]);
            end
            h2_next[k] = h ^ (h >> 15);
        end
    end

    always_comb
    begin
        logic [31:0] h;
        gng_pkg::sword_t dx, dy, dz, s;
        for (int k = 0; k < 8; k++)
        begin
            h = h3_reg[k] ^ (h3_reg[k] >> 13);
            dx = k[2] ? {16'hFFFF, s3_frac_reg[0]} : {16'h0000, s3_frac_reg[0]};
            dy = k[1] ? {16'hFFFF, s3_frac_reg[1]} : {16'h0000, s3_frac_reg[1]};
            dz = k[0] ? {16'hFFFF, s3_frac_reg[2]} : {16'h0000, s3_frac_reg[2]};
            case (s3_ctl_reg.dims)
                gng_pkg::DIMS_2:
                begin
                    s = gng_pkg::grad_term(h[1:0], dx) + gng_pkg::grad_term(h[2:1], dy);
                    g_next[k] = s >>> 2;
                end
                gng_pkg::DIMS_3:
                begin
                    s = gng_pkg::grad_term(h[1:0], dx) + gng_pkg::grad_term(h[3:2], dy)
                        + gng_pkg::grad_term(h[4:3], dz);
                    g_next[k] = gng_pkg::sword_t'(s * gng_pkg::GRAD3_MUL) >>> 9;
                end
                default:
                begin
                    h = h ^ (h >> 7);
                    s = gng_pkg::grad_term(h[1:0], dx);
                    g_next[k] = s >>> 1;
                end
            endcase
        end
    end

    assign out_ctl = s4_ctl_reg;
    assign grad    = g_reg;

endmodule

FILE: rtl/gng_blend.sv
// Five-stage nested interpolation, scaling and output formatting.
module gng_blend (
    input  logic                clk,
    input  logic                rst_n,
    input  gng_pkg::ctl_t       in_ctl,
    input  gng_pkg::grad_arr_t  grad,
    input  gng_pkg::ease_arr_t  ease,
    output logic                out_valid,
    output logic signed [15:0]  raw_out,
    output logic [15:0]         value_out
);

    gng_pkg::ctl_t   b1_ctl_reg, b2_ctl_reg, b3_ctl_reg, b4_ctl_reg;
    gng_pkg::sword_t n_reg [4];
    gng_pkg::sword_t m_reg [2];
    gng_pkg::sword_t raw_reg, raw4_reg, prod_reg;
    gng_pkg::ease_t  t1_reg, t2_reg, t2b_reg;
    gng_pkg::sword_t v;
    logic            valid_reg;
    logic signed [15:0] raw_out_reg;
    logic [15:0]     value_reg;

    function automatic logic [11:0] scale_in(input gng_pkg::ctl_t c);
        logic [11:0] r;
        case ({c.byte_mode, c.dims})
            {1'b0, gng_pkg::DIMS_2}: r = gng_pkg::SCALE_2D;
            {1'b0, gng_pkg::DIMS_3}: r = gng_pkg::SCALE_3D;
            {1'b1, gng_pkg::DIMS_1}: r = gng_pkg::SCALE_1DB;
            {1'b1, gng_pkg::DIMS_2}: r = gng_pkg::SCALE_2DB;
            {1'b1, gng_pkg::DIMS_3}: r = gng_pkg::SCALE_3DB;
            default:                 r = gng_pkg::SCALE_1D;
        endcase
        return r;
    endfunction

    function automatic gng_pkg::sword_t offset_in(input gng_pkg::ctl_t c);
        gng_pkg::sword_t r;
        case ({c.byte_mode, c.dims})
            {1'b0, gng_pkg::DIMS_2}: r = gng_pkg::OFFSET_2D;
            {1'b0, gng_pkg::DIMS_3}: r = gng_pkg::OFFSET_3D;
            {1'b1, gng_pkg::DIMS_1}: r = gng_pkg::OFFSET_1DB;
            {1'b1, gng_pkg::DIMS_2}: r = gng_pkg::OFFSET_2DB;
            {1'b1, gng_pkg::DIMS_3}: r = gng_pkg::OFFSET_3DB;
            default:                 r = gng_pkg::OFFSET_1D;
        endcase
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_ctl_reg <= '0;
            b2_ctl_reg <= '0;
            b3_ctl_reg <= '0;
            b4_ctl_reg <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            b1_ctl_reg <= in_ctl;
            b2_ctl_reg <= b1_ctl_reg;
            b3_ctl_reg <= b2_ctl_reg;
            b4_ctl_reg <= b3_ctl_reg;
            valid_reg  <= b4_ctl_reg.valid;
        end
    end

    always_comb
    begin
        v = (prod_reg >>> 10) + offset_in(b4_ctl_reg);
    end

    always_ff @(posedge clk)
    begin
        n_reg[0] <= gng_pkg::lerp(grad[0], grad[4], ease[0]);
        n_reg[1] <= gng_pkg::lerp(grad[2], grad[6], ease[0]);
        n_reg[2] <= gng_pkg::lerp(grad[1], grad[5], ease[0]);
        n_reg[3] <= gng_pkg::lerp(grad[3], grad[7], ease[0]);
        t1_reg   <= ease[1];
        t2_reg   <= ease[2];
        m_reg[0] <= gng_pkg::lerp(n_reg[0], n_reg[1], t1_reg);
        m_reg[1] <= gng_pkg::lerp(n_reg[2], n_reg[3], t1_reg);
        t2b_reg  <= t2_reg;
        raw_reg  <= gng_pkg::lerp(m_reg[0], m_reg[1], t2b_reg);
        prod_reg <= gng_pkg::sword_t'(raw_reg * $signed({20'd0, scale_in(b3_ctl_reg)}));
        raw4_reg <= raw_reg;
        raw_out_reg <= raw4_reg[15:0];
        value_reg   <= b4_ctl_reg.byte_mode ? {8'd0, v[15:8]} : v[15:0];
    end

    assign out_valid = valid_reg;
    assign raw_out   = raw_out_reg;
    assign value_out = value_reg;

endmodule

FILE: tb/tb_gradient_noise_generator_unit.sv
// Testbench of the gradient noise generator: directed and random items against a predictor.
module tb_gradient_noise_generator_unit;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [1:0]  dims;
        logic        bm;
    } coord_item_t;

    typedef struct {
        logic [15:0] raw;
        logic [15:0] value;
    } noise_result_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [31:0]        coord_x;
    logic [31:0]        coord_y;
    logic [31:0]        coord_z;
    logic [1:0]         num_dims;
    logic               byte_mode;
    logic               done;
    logic signed [15:0] raw_noise;
    logic [15:0]        noise_value;

    coord_item_t   pending_items[$];
    noise_result_t expected_noise[$];
    int            mismatches;
    int            gap_left;
    bit            stimulus_done;

    gradient_noise_generator_unit uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .num_dims(num_dims), .byte_mode(byte_mode), .done(done),
        .raw_noise(raw_noise), .noise_value(noise_value)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic signed [31:0] corner_slope(logic [31:0] h);
        return $signed({30'd0, h[1:0]}) - 32'sd2;
    endfunction

    function automatic logic signed [31:0] corner_grad(int dims, logic [31:0] cx,
            logic signed [31:0] dx, logic [31:0] cy, logic signed [31:0] dy,
            logic [31:0] cz, logic signed [31:0] dz);
        logic [31:0] h;
        logic signed [31:0] s;
        if (dims == 1)
        begin
            h = cx * 32'h27D4EB2D;
            h ^= h >> 15;
            h *= 32'h92C3412B;
            h ^= h >> 13;
            h ^= h >> 7;
            s = corner_slope(h) * dx;
            return s >>> 1;
        end
        if (dims == 2)
        begin
            h = (cx * 32'h27D4EB2D) ^ (cy * 32'hB5297A4D);
            h ^= h >> 15;
            h *= 32'h92C3412B;
            h ^= h >> 13;
            s = corner_slope(h) * dx + corner_slope(h >> 1) * dy;
            return s >>> 2;
        end
        h = (cx * 32'h27D4EB2D) ^ (cy * 32'hB5297A4D) ^ (cz * 32'h1B56C4E9);
        h ^= h >> 15;
        h *= 32'h92C3412B;
        h ^= h >> 13;
        s = corner_slope(h) * dx + corner_slope(h >> 2) * dy + corner_slope(h >> 3) * dz;
        s = s * 32'sd85;
        return s >>> 9;
    endfunction

    function automatic logic signed [31:0] smooth_weight(logic [31:0] t);
        logic [31:0] sq;
        logic [31:0] f;
        logic [31:0] p;
        sq = (t * t) >> 16;
        f = (32'd3 << 16) - (t << 1);
        p = sq * f;
        return $signed(p >> 18);
    endfunction

    function automatic logic signed [31:0] mix(logic signed [31:0] a,
            logic signed [31:0] b, logic signed [31:0] t);
        logic signed [31:0] p;
        p = (b - a) * t;
        return a + (p >>> 14);
    endfunction

    function automatic noise_result_t predict_noise(coord_item_t it);
        logic [31:0] c[3];
        logic [31:0] lo[3];
        logic [31:0] hi[3];
        logic signed [31:0] d0[3];
        logic signed [31:0] d1[3];
        logic signed [31:0] t[3];
        logic signed [31:0] g[8];
        logic signed [31:0] n[4];
        logic signed [31:0] raw;
        logic signed [31:0] mul;
        logic signed [31:0] off;
        logic signed [31:0] v;
        int dims;
        noise_result_t r;
        c[0] = it.x;
        c[1] = it.y;
        c[2] = it.z;
        dims = (it.dims == 2'd0) ? 1 : int'(it.dims);
        for (int i = 0; i < 3; i++)
        begin
            if (it.bm)
                c[i] = {8'd0, c[i][15:0], 8'd0};
            lo[i] = c[i] >> 16;
            hi[i] = lo[i] + 32'd1;
            if (it.bm)
                hi[i] &= 32'hFF;
            d0[i] = $signed({16'd0, c[i][15:0]});
            d1[i] = d0[i] - 32'sh10000;
            t[i] = smooth_weight(d0[i]);
        end
        if (dims == 1)
        begin
            raw = mix(corner_grad(1, lo[0], d0[0], 0, 0, 0, 0),
                      corner_grad(1, hi[0], d1[0], 0, 0, 0, 0), t[0]);
            mul = it.bm ? 32'sd1353 : 32'sd1159;
            off = it.bm ? 32'sd32769 : 32'sd32803;
        end
        else if (dims == 2)
        begin
            n[0] = mix(corner_grad(2, lo[0], d0[0], lo[1], d0[1], 0, 0),
                       corner_grad(2, hi[0], d1[0], lo[1], d0[1], 0, 0), t[0]);
            n[1] = mix(corner_grad(2, lo[0], d0[0], hi[1], d1[1], 0, 0),
                       corner_grad(2, hi[0], d1[0], hi[1], d1[1], 0, 0), t[0]);
            raw = mix(n[0], n[1], t[1]);
            mul = it.bm ? 32'sd1620 : 32'sd1537;
            off = it.bm ? 32'sd32771 : 32'sd32725;
        end
        else
        begin
            for (int k = 0; k < 8; k++)
                g[k] = corner_grad(3, k[2] ? hi[0] : lo[0], k[2] ? d1[0] : d0[0],
                                   k[1] ? hi[1] : lo[1], k[1] ? d1[1] : d0[1],
                                   k[0] ? hi[2] : lo[2], k[0] ? d1[2] : d0[2]);
            n[0] = mix(g[0], g[4], t[0]);
            n[1] = mix(g[2], g[6], t[0]);
            n[2] = mix(g[1], g[5], t[0]);
            n[3] = mix(g[3], g[7], t[0]);
            raw = mix(mix(n[0], n[1], t[1]), mix(n[2], n[3], t[1]), t[2]);
            mul = it.bm ? 32'sd2015 : 32'sd1731;
            off = it.bm ? 32'sd33168 : 32'sd33147;
        end
        v = ((raw * mul) >>> 10) + off;
        r.raw = raw[15:0];
        r.value = it.bm ? {8'd0, 8'(v >>> 8)} : v[15:0];
        return r;
    endfunction

    task automatic queue_item(logic [31:0] x, logic [31:0] y, logic [31:0] z,
            logic [1:0] dims, logic bm);
        coord_item_t it;
        it.x = x;
        it.y = y;
        it.z = z;
        it.dims = dims;
        it.bm = bm;
        pending_items.push_back(it);
    endtask

    function automatic logic [31:0] random_coord();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFFFFFF;
            2: return {$urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom), 16'($urandom)};
            3: return {16'($urandom), $urandom_range(0, 1) ? 16'hFFFF : 16'h0};
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        for (int d = 0; d < 4; d++)
            for (int b = 0; b < 2; b++)
            begin
                queue_item(32'h0, 32'h0, 32'h0, 2'(d), 1'(b));
                queue_item(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 2'(d), 1'(b));
            end
        queue_item(32'hFFFF8000, 32'h0001_8000, 32'hFFFF_0001, 2'd3, 1'b0);
        queue_item(32'h0000FF80, 32'h0000FF00, 32'h000000FF, 2'd3, 1'b1);
        queue_item(32'h12348000, 32'hAAAA5555, 32'h5555AAAA, 2'd1, 1'b0);
        queue_item(32'h0000_8000, 32'hDEAD_BEEF, 32'hCAFE_F00D, 2'd2, 1'b0);
        queue_item(32'hABCD_FF01, 32'h1234_00FF, 32'h0, 2'd2, 1'b1);
        for (int i = 0; i < 2000; i++)
            queue_item(random_coord(), random_coord(), random_coord(),
                       2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        stimulus_done = 1'b1;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            coord_x <= '0;
            coord_y <= '0;
            coord_z <= '0;
            num_dims <= 2'd1;
            byte_mode <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
                expected_noise.push_back(predict_noise('{coord_x, coord_y, coord_z,
                                                         num_dims, byte_mode}));
            if (start && busy)
                start <= 1'b1;
            else if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_items.size() > 0)
            begin
                coord_item_t it;
                it = pending_items.pop_front();
                coord_x <= it.x;
                coord_y <= it.y;
                coord_z <= it.z;
                num_dims <= it.dims;
                byte_mode <= it.bm;
                start <= 1'b1;
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_noise.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result raw=%h value=%h", raw_noise, noise_value);
            end
            else
            begin
                noise_result_t e;
                e = expected_noise.pop_front();
                if (e.raw !== raw_noise || e.value !== noise_value)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch raw exp=%h got=%h value exp=%h got=%h",
                                 e.raw, raw_noise, e.value, noise_value);
                end
            end
        end
    end

    initial
    begin
        mismatches = 0;
        wait (rst_n && stimulus_done);
        wait (pending_items.size() == 0 && !start);
        wait (expected_noise.size() == 0);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_noise.size() == 0)
            $display("[gradient_noise_generator_unit] OK");
        else
            $display("[gradient_noise_generator_unit] ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("[gradient_noise_generator_unit] ERROR");
        $finish;
    end
endmodule

FILE: gradient_noise_generator_unit.f
rtl/gng_pkg.sv
rtl/gng_ease.sv
rtl/gng_hash.sv
rtl/gng_blend.sv
rtl/gradient_noise_generator_unit.sv
tb/tb_gradient_noise_generator_unit.sv
